/* rtl/bnpe_pkg.sv */
// ----------------------------------------------------------------------------
// bnpe_pkg: shared types, constants and functions for the NAND page ECC block
// BCH over GF(2^13), t = 4, field polynomial 0x201b; 52-bit check remainder.
// ----------------------------------------------------------------------------
package bnpe_pkg;

    // Default page geometry
    localparam int SECTOR_BYTES_DEF = 512;
    localparam int SECTOR_COUNT_DEF = 4;
    localparam int SPARE_BYTES_DEF  = 16;
    localparam int ECC_START_DEF    = 9;

    // Code constants
    localparam int             GF_BITS       = 13;
    localparam logic [13:0]    GF_POLY       = 14'h201b;
    localparam int             CORR_T        = 4;
    localparam int             ECC_BITS      = 52;
    localparam int             ECC_OUT_BYTES = 7;
    localparam int             ECC_WORD_W    = ECC_BITS + 4;
    localparam logic [7:0]     ERASED_BYTE   = 8'hff;

    // What a page byte does to its sector's remainder
    typedef enum logic [1:0] {
        K_DATA,     // sector data: fed 8 bits, checked for erased
        K_FULL,     // spare byte before the ECC area: fed 8 bits
        K_NIB,      // first ECC byte: high nibble fed and kept
        K_SKIP      // rest of the spare region: ignored
    } t_kind;

    typedef struct packed {
        logic       last;   // last byte of the page
        t_kind      kind;
        logic [7:0] data;
    } t_acc_cmd;

    function automatic logic [GF_BITS-1:0] gf_mul(input logic [GF_BITS-1:0] a,
                                                  input logic [GF_BITS-1:0] b);
        logic [GF_BITS:0]   x;
        logic [GF_BITS-1:0] y;
        logic [GF_BITS-1:0] acc;
        x   = {1'b0, a};
        y   = b;
        acc = '0;
        for (int k = 0; k < GF_BITS; k++) begin
            if (y[0]) acc ^= x[GF_BITS-1:0];
            y = y >> 1;
            x = x << 1;
            if (x[GF_BITS]) x ^= GF_POLY;
        end
        return acc;
    endfunction

    // alpha^e by square and multiply
    function automatic logic [GF_BITS-1:0] gf_pow(input logic [GF_BITS-1:0] e);
        logic [GF_BITS-1:0] res;
        logic [GF_BITS-1:0] base;
        res  = GF_BITS'(1);
        base = GF_BITS'(2);
        for (int k = 0; k < GF_BITS; k++) begin
            if (e[k]) res = gf_mul(res, base);
            base = gf_mul(base, base);
        end
        return res;
    endfunction

    // Generator polynomial (low 52 coefficients): product of (x + alpha^r)
    // over the conjugacy classes of alpha^1, alpha^3, alpha^5, alpha^7.
    function automatic logic [ECC_BITS-1:0] gen_poly();
        logic [GF_BITS-1:0]  coef [0:ECC_BITS];
        logic [GF_BITS-1:0]  a;
        logic [ECC_BITS-1:0] g;
        int                  deg;
        for (int c = 0; c <= ECC_BITS; c++) coef[c] = '0;
        coef[0] = GF_BITS'(1);
        deg     = 0;
        for (int i = 0; i < CORR_T; i++) begin
            a = gf_pow(GF_BITS'(2 * i + 1));
            for (int j = 0; j < GF_BITS; j++) begin
                coef[deg+1] = coef[deg];
                for (int k = ECC_BITS; k >= 1; k--) begin
                    if (k <= deg) coef[k] = coef[k-1] ^ gf_mul(coef[k], a);
                end
                coef[0] = gf_mul(coef[0], a);
                deg++;
                a = gf_mul(a, a);
            end
        end
        for (int k = 0; k < ECC_BITS; k++) g[k] = coef[k][0];
        return g;
    endfunction

    localparam logic [ECC_BITS-1:0] GEN_LOW = gen_poly();

    // Byte-wide LFSR update, MSB first; nib_only feeds bits 7:4 alone
    function automatic logic [ECC_BITS-1:0] lfsr_feed(input logic [ECC_BITS-1:0] rem,
                                                      input logic [7:0] bits,
                                                      input logic nib_only);
        logic [ECC_BITS-1:0] r;
        logic                fb;
        r = rem;
        for (int k = 7; k >= 0; k--) begin
            if (!nib_only || k >= 4) begin
                fb = bits[k] ^ r[ECC_BITS-1];
                r  = r << 1;
                if (fb) r ^= GEN_LOW;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/bnpe_ecc_acc.sv */
// ----------------------------------------------------------------------------
// bnpe_ecc_acc: per-sector BCH remainder accumulator
// Input register, one byte-wide LFSR update, per-sector state; presents the
// finished page words for one cycle when the page's last byte is processed.
// ----------------------------------------------------------------------------
module bnpe_ecc_acc #(
    parameter  int SECTOR_COUNT = bnpe_pkg::SECTOR_COUNT_DEF,
    localparam int SEC_W        = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  bnpe_pkg::t_acc_cmd                i_cmd,
    input  logic [SEC_W-1:0]                  i_cmd_sec,
    output logic                              o_snap_valid,
    output logic                              o_snap_erased,
    output logic [bnpe_pkg::ECC_WORD_W-1:0]   o_snap_word [SECTOR_COUNT]
);
    import bnpe_pkg::*;

    logic                r_cmd_valid;
    t_acc_cmd            r_cmd;
    logic [SEC_W-1:0]    r_sec;
    logic [ECC_BITS-1:0] r_rem [SECTOR_COUNT];
    logic [3:0]          r_nib [SECTOR_COUNT];
    logic                r_erased;

    logic [ECC_BITS-1:0] n_rem_sel;
    logic [3:0]          n_nib_sel;
    logic                n_erased;

    always_comb begin
        n_rem_sel = r_rem[r_sec];
        n_nib_sel = r_nib[r_sec];
        n_erased  = r_erased;
        if (r_cmd_valid) begin
            case (r_cmd.kind)
                K_DATA: begin
                    n_rem_sel = lfsr_feed(r_rem[r_sec], r_cmd.data, 1'b0);
                    if (r_cmd.data != ERASED_BYTE) n_erased = 1'b0;
                end
                K_FULL: begin
                    n_rem_sel = lfsr_feed(r_rem[r_sec], r_cmd.data, 1'b0);
                end
                K_NIB: begin
                    n_rem_sel = lfsr_feed(r_rem[r_sec], r_cmd.data, 1'b1);
                    n_nib_sel = r_cmd.data[7:4];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int s = 0; s < SECTOR_COUNT; s++) begin
            if (SEC_W'(s) == r_sec) o_snap_word[s] = {n_nib_sel, n_rem_sel};
            else                    o_snap_word[s] = {r_nib[s], r_rem[s]};
        end
    end

    assign o_snap_valid  = r_cmd_valid && r_cmd.last;
    assign o_snap_erased = n_erased;

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            r_cmd <= i_cmd;
            r_sec <= i_cmd_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_erased    <= 1'b1;
            for (int s = 0; s < SECTOR_COUNT; s++) begin
                r_rem[s] <= '0;
                r_nib[s] <= '0;
            end
        end else begin
            r_cmd_valid <= i_cmd_valid;
            if (o_snap_valid) begin
                // page done: start the next one clean
                r_erased <= 1'b1;
                for (int s = 0; s < SECTOR_COUNT; s++) begin
                    r_rem[s] <= '0;
                    r_nib[s] <= '0;
                end
            end else if (r_cmd_valid) begin
                r_rem[r_sec] <= n_rem_sel;
                r_nib[r_sec] <= n_nib_sel;
                r_erased     <= n_erased;
            end
        end
    end

endmodule

/* rtl/bch_nand_page_ecc_top.sv */
// ----------------------------------------------------------------------------
// bch_nand_page_ecc_top: BCH (m = 13, t = 4) ECC generator for a raw NAND page
//
// Input channel (i_valid / o_stall / i_page_byte): one page byte per transfer,
// SECTOR_COUNT sectors of SECTOR_BYTES data bytes, then SECTOR_COUNT spare
// regions of SPARE_BYTES bytes. One byte is taken per cycle when not stalled.
// Output channel (o_valid / i_stall / o_sector, o_ecc_index, o_ecc_value,
// o_final_byte): after the last byte of a page, 7 * SECTOR_COUNT transfers,
// sector by sector, bytes for spare offsets ECC_START .. ECC_START+6.
// o_valid rises once the page's last byte has passed the accumulator's input
// register and the buffer's busy flag r_e_busy has been registered; the ECC
// transfers follow one per cycle while i_stall is low.
// The ECC bytes are held in a page buffer, so the next page streams in while
// they drain. Only the next page's last byte waits (o_stall high) if the
// buffer still holds undelivered bytes; with no output stalls the input is
// never held. The work per byte is one byte-wide LFSR update between the
// input register and the remainder registers.
// Reset (i_rst_n low, synchronous) clears position, remainders, the erased
// flag and the output buffer; the next byte starts a new page.
// An all-0xFF data area yields 0xFF for every ECC byte.
// ----------------------------------------------------------------------------
module bch_nand_page_ecc_top #(
    parameter  int SECTOR_BYTES = bnpe_pkg::SECTOR_BYTES_DEF,
    parameter  int SECTOR_COUNT = bnpe_pkg::SECTOR_COUNT_DEF,
    parameter  int SPARE_BYTES  = bnpe_pkg::SPARE_BYTES_DEF,
    parameter  int ECC_START    = bnpe_pkg::ECC_START_DEF,
    localparam int SEC_W        = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // page byte channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_page_byte,
    // ECC byte channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic [SEC_W-1:0] o_sector,
    output logic [2:0]       o_ecc_index,
    output logic [7:0]       o_ecc_value,
    output logic             o_final_byte
);
    import bnpe_pkg::*;

    // offset counter is sized for the data sector, the larger region by default
    localparam int OFF_W = $clog2(SECTOR_BYTES);

    // ------------------------------------------------------------------
    // Page position: offset in region, sector, data/spare phase
    // ------------------------------------------------------------------
    logic [OFF_W-1:0] r_off;
    logic [SEC_W-1:0] r_sec;
    logic             r_spare;

    logic             w_in_xfer;
    logic             w_region_end;
    logic             w_sec_end;
    logic             w_page_end;
    t_acc_cmd         w_cmd;

    assign w_region_end = r_spare ? (r_off == OFF_W'(SPARE_BYTES - 1))
                                  : (r_off == OFF_W'(SECTOR_BYTES - 1));
    assign w_sec_end    = (r_sec == SEC_W'(SECTOR_COUNT - 1));
    assign w_page_end   = r_spare && w_region_end && w_sec_end;

    always_comb begin
        w_cmd.last = w_page_end;
        w_cmd.data = i_page_byte;
        if (!r_spare)                       w_cmd.kind = K_DATA;
        else if (r_off < OFF_W'(ECC_START)) w_cmd.kind = K_FULL;
        else if (r_off == OFF_W'(ECC_START)) w_cmd.kind = K_NIB;
        else                                w_cmd.kind = K_SKIP;
    end

    // ------------------------------------------------------------------
    // Output buffer state (declared here, used by the stall term)
    // ------------------------------------------------------------------
    logic                  r_e_busy;
    logic [SEC_W-1:0]      r_e_sec;
    logic [2:0]            r_e_idx;
    logic                  r_e_erased;
    logic [ECC_WORD_W-1:0] r_e_word [SECTOR_COUNT];

    // hold the page's last byte until the previous page's ECC has drained
    assign o_stall   = w_page_end && r_e_busy;
    assign w_in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_sec   <= '0;
            r_spare <= 1'b0;
        end else if (w_in_xfer) begin
            if (w_region_end) begin
                r_off <= '0;
                if (w_sec_end) begin
                    r_sec   <= '0;
                    r_spare <= !r_spare;
                end else begin
                    r_sec <= r_sec + SEC_W'(1);
                end
            end else begin
                r_off <= r_off + OFF_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Remainder accumulation
    // ------------------------------------------------------------------
    logic                  w_snap_valid;
    logic                  w_snap_erased;
    logic [ECC_WORD_W-1:0] w_snap_word [SECTOR_COUNT];

    bnpe_ecc_acc #(
        .SECTOR_COUNT (SECTOR_COUNT)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_in_xfer),
        .i_cmd         (w_cmd),
        .i_cmd_sec     (r_sec),
        .o_snap_valid  (w_snap_valid),
        .o_snap_erased (w_snap_erased),
        .o_snap_word   (w_snap_word)
    );

    // ------------------------------------------------------------------
    // ECC byte buffer and output sequencing
    // ------------------------------------------------------------------
    logic                  w_out_xfer;
    logic                  w_last_out;
    logic [ECC_WORD_W-1:0] w_sel_word;
    logic [5:0]            w_bit_lo;

    assign w_last_out = (r_e_sec == SEC_W'(SECTOR_COUNT - 1))
                     && (r_e_idx == 3'(ECC_OUT_BYTES - 1));
    assign w_out_xfer = r_e_busy && !i_stall;

    // byte 0 carries the user nibble and the top remainder bits
    assign w_sel_word = r_e_word[r_e_sec];
    assign w_bit_lo   = 6'(8 * (ECC_OUT_BYTES - 1 - int'(r_e_idx)));

    assign o_valid      = r_e_busy;
    assign o_sector     = r_e_sec;
    assign o_ecc_index  = r_e_idx;
    assign o_ecc_value  = r_e_erased ? ERASED_BYTE : w_sel_word[w_bit_lo +: 8];
    assign o_final_byte = w_last_out;

    always_ff @(posedge i_clk) begin
        if (w_snap_valid) begin
            r_e_erased <= w_snap_erased;
            for (int s = 0; s < SECTOR_COUNT; s++) r_e_word[s] <= w_snap_word[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_busy <= 1'b0;
            r_e_sec  <= '0;
            r_e_idx  <= '0;
        end else if (w_snap_valid) begin
            r_e_busy <= 1'b1;
            r_e_sec  <= '0;
            r_e_idx  <= '0;
        end else if (w_out_xfer) begin
            if (w_last_out) begin
                r_e_busy <= 1'b0;
            end else if (r_e_idx == 3'(ECC_OUT_BYTES - 1)) begin
                r_e_idx <= '0;
                r_e_sec <= r_e_sec + SEC_W'(1);
            end else begin
                r_e_idx <= r_e_idx + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a finished page never lands on a buffer that still holds ECC bytes
    a_snap_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_valid |-> !r_e_busy)
        else $error("page snapshot while ECC buffer busy");

    // after the final ECC byte moves, the channel goes quiet
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_final_byte) |=> !o_valid)
        else $error("ECC output still valid after final byte");

    // spare offset stays inside the spare region
    a_spare_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare |-> (r_off < OFF_W'(SPARE_BYTES)))
        else $error("spare offset out of range");

    // an accepted page-end byte reaches the snapshot at the next edge
    a_page_end_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_page_end) |=> w_snap_valid)
        else $error("page end not followed by snapshot");

endmodule
